// ===== hw/rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Types and constants shared by the SHA-256 digest front end and engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  // one packed word written into the block queue
  typedef struct packed {
    logic [31:0] data;
    logic [3:0]  index;   // word position within the block
    logic        blk_end; // last word of a block
    logic        msg_end; // block ends the message
  } word_xact_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_LOAD,
    ENG_ROUND,
    ENG_OUT
  } eng_state_t;

  typedef enum logic [1:0] {
    FE_BYTES,
    FE_PAD,
    FE_LEN
  } fe_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_message_digest_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_digest_core
// SHA-256 digest of a byte stream, one byte per input transaction.
// ----------------------------------------------------------------------------
// Input channel: data_byte, byte_present and last with valid/ready. A
// transaction marked last ends the message; byte_present 0 adds no byte.
// Output channel: eight transactions digest_word/word_index/last_word with
// out_valid/out_ready, word 0 first, last_word on the eighth.
// Bytes are packed into words by the front end and pass a two-entry queue
// to the engine: a start state, the sixteen loaded words and 64 rounds per
// block. Input is taken at one byte per cycle while bytes are collected,
// until two words wait during the rounds; the block rate is set by the
// single shared round unit. A last transaction adds one or two padded
// blocks, then the eight words leave at one per cycle while out_ready is
// high.
// Reset returns the hash state to the initial values and empties the queue.
// While out_ready is low the engine holds its digest and the queue fills,
// which then drops ready on the input channel.
// ----------------------------------------------------------------------------
module sha256_message_digest_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last,
  input  wire logic        valid,
  output logic             ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             out_valid,
  input  wire logic        out_ready
);

  sha_pkg::word_xact_t fw, qw;
  logic fv, fr, qv, qr;

  sha_front u_front (
    .clk, .rst, .data_byte, .byte_present, .last, .valid, .ready,
    .wr_word(fw), .wr_valid(fv), .wr_ready(fr)
  );

  sha_queue u_queue (
    .clk, .rst, .in_word(fw), .in_valid(fv), .in_ready(fr),
    .out_word(qw), .out_valid(qv), .out_ready(qr)
  );

  sha_engine u_engine (
    .clk, .rst, .rd_word(qw), .rd_valid(qv), .rd_ready(qr),
    .digest_word, .word_index, .last_word, .out_valid, .out_ready
  );

  // the eighth word is flagged last
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  // words leave in order
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (word_index == $past(word_index) + 3'd1))
    else $error("digest word order");

  // a digest word stays offered until it is taken
  a_no_ready_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("digest dropped");

endmodule
`default_nettype wire

// ===== hw/rtl/sha_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into 32-bit words, appends padding and bit length.
// ----------------------------------------------------------------------------
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire logic              byte_present,
  input  wire logic              last,
  input  wire logic              valid,
  output logic                   ready,
  output sha_pkg::word_xact_t    wr_word,
  output logic                   wr_valid,
  input  wire logic              wr_ready
);

  sha_pkg::fe_state_t state, state_next;
  logic [60:0] byte_count;
  logic [60:0] count_next; // length after the byte taken now
  logic [23:0] partial;    // earlier bytes of the current word
  logic [31:0] merged;
  logic [63:0] bit_len;
  logic        len_hi;     // which half of the length goes next
  logic        mark_done;  // word holding 0x80 already pushed
  logic [3:0]  pad_word;   // next pad word position in the block
  logic        accept;
  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [1:0]  bidx;

  // word assembled from partial bytes plus the byte appended now
  function automatic logic [31:0] merge(input logic [23:0] p, input logic [1:0] b,
                                        input logic [7:0] v);
    logic [31:0] w;
    w = 32'h0;
    unique case (b)
      2'd0: w = {v, 24'h0};
      2'd1: w = {p[23:16], v, 16'h0};
      2'd2: w = {p[23:8], v, 8'h0};
      2'd3: w = {p, v};
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  assign pos        = byte_count[5:0];
  assign widx       = pos[5:2];
  assign bidx       = pos[1:0];
  assign bit_len    = {byte_count, 3'b000};
  assign merged     = merge(partial, bidx, data_byte);
  assign count_next = byte_present ? byte_count + 61'd1 : byte_count;

  // ready only while collecting bytes and a word push can be taken
  assign ready  = (state == sha_pkg::FE_BYTES) && wr_ready;
  assign accept = valid && ready;

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::FE_BYTES: if (accept && last) state_next = sha_pkg::FE_PAD;
      sha_pkg::FE_PAD:   if (wr_ready && pad_word == 4'd13) state_next = sha_pkg::FE_LEN;
      sha_pkg::FE_LEN:   if (wr_ready && len_hi == 1'b0) state_next = sha_pkg::FE_BYTES;
      default:           state_next = sha_pkg::FE_BYTES;
    endcase
  end

  // word push outputs
  always_comb begin
    wr_valid  = 1'b0;
    wr_word   = '0;
    unique case (state)
      sha_pkg::FE_BYTES: begin
        wr_valid      = valid && byte_present && (bidx == 2'd3);
        wr_word.data  = merged;
        wr_word.index = widx;
        wr_word.blk_end = (widx == 4'd15);
      end
      sha_pkg::FE_PAD: begin
        // 0x80 follows the message bytes in the first pad word, zeros after
        wr_valid      = 1'b1;
        wr_word.data  = mark_done ? 32'h0 : merge(partial, bidx, 8'h80);
        wr_word.index = pad_word;
        wr_word.blk_end = (pad_word == 4'd15);
      end
      sha_pkg::FE_LEN: begin
        wr_valid      = 1'b1;
        wr_word.data  = len_hi ? bit_len[63:32] : bit_len[31:0];
        wr_word.index = len_hi ? 4'd14 : 4'd15;
        wr_word.blk_end = !len_hi;
        wr_word.msg_end = !len_hi;
      end
      default: ;
    endcase
  end

  // counters, partial word and pad position
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha_pkg::FE_BYTES;
      byte_count <= '0;
      len_hi     <= 1'b1;
      partial    <= '0;
      mark_done  <= 1'b0;
      pad_word   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        sha_pkg::FE_BYTES: begin
          if (accept) begin
            byte_count <= count_next;
            if (byte_present) partial <= (bidx == 2'd3) ? 24'h0 : merged[31:8];
            pad_word  <= count_next[5:2];
            mark_done <= 1'b0;
          end
        end
        sha_pkg::FE_PAD: begin
          if (wr_ready) begin
            // next word slot, wrapping into a second block when needed
            mark_done <= 1'b1;
            pad_word  <= pad_word + 4'd1;
          end
        end
        sha_pkg::FE_LEN: begin
          if (wr_ready) begin
            len_hi <= ~len_hi;
            if (!len_hi) begin
              byte_count <= '0;
              partial    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_engine
// Block queue consumer: message schedule, 64 compression rounds, digest out.
// ----------------------------------------------------------------------------
module sha_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  sha_pkg::word_xact_t    rd_word,
  input  wire logic              rd_valid,
  output logic                   rd_ready,
  output logic [31:0]            digest_word,
  output logic [2:0]             word_index,
  output logic                   last_word,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  sha_pkg::eng_state_t state, state_next;
  logic [31:0] hw [8];
  logic [31:0] v  [8];
  logic [31:0] w  [16];     // sliding schedule window
  logic [5:0]  rnd;
  logic        msg_end;
  logic [2:0]  oidx;

  logic [31:0] s0, s1, wnew, t1, t2, wcur;
  assign wcur = w[0];
  assign s0 = sha_pkg::ror32(w[1], 7) ^ sha_pkg::ror32(w[1], 18) ^ (w[1] >> 3);
  assign s1 = sha_pkg::ror32(w[14], 17) ^ sha_pkg::ror32(w[14], 19) ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign t1 = v[7] + (sha_pkg::ror32(v[4], 6) ^ sha_pkg::ror32(v[4], 11)
              ^ sha_pkg::ror32(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
              + sha_pkg::round_k(rnd) + wcur;
  assign t2 = (sha_pkg::ror32(v[0], 2) ^ sha_pkg::ror32(v[0], 13)
              ^ sha_pkg::ror32(v[0], 22)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ENG_IDLE:  if (rd_valid) state_next = sha_pkg::ENG_LOAD;
      sha_pkg::ENG_LOAD:  if (rd_valid && rd_word.blk_end) state_next = sha_pkg::ENG_ROUND;
      sha_pkg::ENG_ROUND: if (rnd == 6'd63)
                            state_next = msg_end ? sha_pkg::ENG_OUT : sha_pkg::ENG_IDLE;
      sha_pkg::ENG_OUT:   if (out_ready && oidx == 3'd7) state_next = sha_pkg::ENG_IDLE;
      default:            state_next = sha_pkg::ENG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rd_ready    = (state == sha_pkg::ENG_LOAD);
    out_valid   = (state == sha_pkg::ENG_OUT);
    digest_word = hw[oidx];
    word_index  = oidx;
    last_word   = (oidx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ENG_IDLE;
      rnd   <= '0;
      oidx  <= '0;
      msg_end <= 1'b0;
      for (int i = 0; i < 8; i++) hw[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      state <= state_next;
      unique case (state)
        sha_pkg::ENG_IDLE: begin
          rnd <= '0;
          for (int i = 0; i < 8; i++) v[i] <= hw[i];
        end
        sha_pkg::ENG_LOAD: begin
          if (rd_valid) begin
            // shift words in so w[0] ends up the first word
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15]   <= rd_word.data;
            msg_end <= rd_word.msg_end;
          end
        end
        sha_pkg::ENG_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            hw[0] <= hw[0] + t1 + t2; hw[1] <= hw[1] + v[0];
            hw[2] <= hw[2] + v[1];    hw[3] <= hw[3] + v[2];
            hw[4] <= hw[4] + v[3] + t1; hw[5] <= hw[5] + v[4];
            hw[6] <= hw[6] + v[5];    hw[7] <= hw[7] + v[6];
          end
        end
        sha_pkg::ENG_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7)
              for (int i = 0; i < 8; i++) hw[i] <= sha_pkg::init_hash(3'(i));
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sha_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_queue
// Two-entry word queue between the front end and the engine.
// ----------------------------------------------------------------------------
module sha_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  sha_pkg::word_xact_t    in_word,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output sha_pkg::word_xact_t    out_word,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  sha_pkg::word_xact_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_word  = mem[rp];

  // storage write
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_word;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule
`default_nettype wire
